[src/mslp_pkg.sv]
package mslp_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int MAX_OUT       = 16;

    localparam logic [2:0] CMD_ALLOC    = 3'd0;
    localparam logic [2:0] CMD_SUBMIT   = 3'd1;
    localparam logic [2:0] CMD_COLL_UNH = 3'd2;
    localparam logic [2:0] CMD_MARK     = 3'd3;
    localparam logic [2:0] CMD_COLL_HND = 3'd4;
    localparam logic [2:0] CMD_FREE     = 3'd5;

    localparam logic [2:0] ST_FREE        = 3'd0;
    localparam logic [2:0] ST_RESERVED    = 3'd1;
    localparam logic [2:0] ST_UNHANDLED   = 3'd2;
    localparam logic [2:0] ST_UNH_CLAIMED = 3'd3;
    localparam logic [2:0] ST_HANDLED     = 3'd4;
    localparam logic [2:0] ST_HND_CLAIMED = 3'd5;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_WRONG = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_NONE  = 2'd3;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_XFER    = 2'd1;
    localparam logic [1:0] OP_COLLECT = 2'd2;
    localparam logic [1:0] OP_REJECT  = 2'd3;

    typedef struct packed {
        logic [2:0] command;
        logic [3:0] slot;
    } in_t;

    typedef struct packed {
        logic [3:0] slot_out;
        logic [1:0] status;
        logic       last;
    } out_t;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] slot;
        logic [2:0] src;
        logic [2:0] dst;
    } job_t;

endpackage

[src/message_slot_lifecycle_pool.sv]
// Submit, mark handled and free pass through the queue, a RAM read, a check and the output
// register; out-of-range or unknown commands go from the queue to the output register.
// Allocate and collect scan the slot-state RAM one slot at a time, a read state then a check
// state per slot (one read port); a two-entry queue keeps taking commands meanwhile.
// Reset (aresetn low, synchronous) sets every slot free through per-slot valid bits;
// there is no clearing pass.
module message_slot_lifecycle_pool #(
    parameter int SLOTS = mslp_pkg::SLOTS_DEFAULT
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  mslp_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output mslp_pkg::out_t m_data
);

    logic           job_valid;
    logic           job_ready;
    mslp_pkg::job_t job;

    mslp_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    mslp_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

[src/mslp_ram.sv]
module mslp_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = mslp_pkg::SLOTS_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[src/mslp_front.sv]
module mslp_front #(
    parameter int SLOTS = mslp_pkg::SLOTS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mslp_pkg::in_t      s_data,
    output logic               job_valid,
    input  logic               job_ready,
    output mslp_pkg::job_t     job
);

    localparam int QD   = 2;
    localparam int QW   = $clog2(QD);
    localparam int CNTW = $clog2(QD + 1);

    mslp_pkg::job_t  q_reg [QD];
    logic [QW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    mslp_pkg::job_t  cls;
    logic            in_range;
    logic            push;
    logic            pop;

    assign in_range = (32'(s_data.slot) < SLOTS);

    always_comb begin
        cls.op   = mslp_pkg::OP_REJECT;
        cls.slot = s_data.slot;
        cls.src  = mslp_pkg::ST_FREE;
        cls.dst  = mslp_pkg::ST_FREE;
        unique case (s_data.command)
            mslp_pkg::CMD_ALLOC: begin
                cls.op  = mslp_pkg::OP_ALLOC;
                cls.src = mslp_pkg::ST_FREE;
                cls.dst = mslp_pkg::ST_RESERVED;
            end
            mslp_pkg::CMD_SUBMIT: begin
                cls.op  = in_range ? mslp_pkg::OP_XFER : mslp_pkg::OP_REJECT;
                cls.src = mslp_pkg::ST_RESERVED;
                cls.dst = mslp_pkg::ST_UNHANDLED;
            end
            mslp_pkg::CMD_COLL_UNH: begin
                cls.op  = mslp_pkg::OP_COLLECT;
                cls.src = mslp_pkg::ST_UNHANDLED;
                cls.dst = mslp_pkg::ST_UNH_CLAIMED;
            end
            mslp_pkg::CMD_MARK: begin
                cls.op  = in_range ? mslp_pkg::OP_XFER : mslp_pkg::OP_REJECT;
                cls.src = mslp_pkg::ST_UNH_CLAIMED;
                cls.dst = mslp_pkg::ST_HANDLED;
            end
            mslp_pkg::CMD_COLL_HND: begin
                cls.op  = mslp_pkg::OP_COLLECT;
                cls.src = mslp_pkg::ST_HANDLED;
                cls.dst = mslp_pkg::ST_HND_CLAIMED;
            end
            mslp_pkg::CMD_FREE: begin
                cls.op  = in_range ? mslp_pkg::OP_XFER : mslp_pkg::OP_REJECT;
                cls.src = mslp_pkg::ST_UNH_CLAIMED;
                cls.dst = mslp_pkg::ST_FREE;
            end
            default: begin
                cls.op = mslp_pkg::OP_REJECT;
            end
        endcase
    end

    assign s_ready   = (cnt_reg != CNTW'(QD));
    assign job_valid = (cnt_reg != '0);
    assign job       = q_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = job_valid && job_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + QW'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + QW'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CNTW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CNTW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

[src/mslp_back.sv]
module mslp_back #(
    parameter int SLOTS = mslp_pkg::SLOTS_DEFAULT
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            job_valid,
    output logic            job_ready,
    input  mslp_pkg::job_t  job,
    output logic            m_valid,
    input  logic            m_ready,
    output mslp_pkg::out_t  m_data
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(mslp_pkg::MAX_OUT + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(SLOTS - 1);
    localparam logic [CW-1:0] CNT_MAX   = CW'(mslp_pkg::MAX_OUT);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RD    = 2'd1;
    localparam logic [1:0] S_CHK   = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0]       state_reg, state_next;
    mslp_pkg::job_t   job_reg, job_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [AW-1:0]    pend_reg, pend_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    cnt_inc;
    logic             out_valid_reg, out_valid_next;
    mslp_pkg::out_t   out_reg, out_next;
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic             rd_valid_reg;
    logic [2:0]       ram_rd_data;
    logic [2:0]       cur_state;
    logic             match;
    logic             out_free;
    logic             wr_en;
    logic             at_last;

    mslp_ram #(
        .WIDTH (3),
        .DEPTH (SLOTS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (addr_reg),
        .wr_data (job_reg.dst),
        .rd_addr (addr_reg),
        .rd_data (ram_rd_data)
    );

    assign out_free  = !out_valid_reg || m_ready;
    assign cur_state = rd_valid_reg ? ram_rd_data : mslp_pkg::ST_FREE;
    assign match     = (cur_state == job_reg.src);
    assign at_last   = (addr_reg == LAST_ADDR);
    assign cnt_inc   = cnt_reg + CW'(1);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    always_comb begin
        state_next     = state_reg;
        job_next       = job_reg;
        addr_next      = addr_reg;
        pend_next      = pend_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        valid_next     = valid_reg;
        job_ready      = 1'b0;
        wr_en          = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (job_valid && (job.op != mslp_pkg::OP_REJECT || out_free)) begin
                    job_ready = 1'b1;
                    job_next  = job;
                    cnt_next  = '0;
                    if (job.op == mslp_pkg::OP_REJECT) begin
                        out_valid_next = 1'b1;
                        out_next = '{slot_out: job.slot, status: mslp_pkg::STAT_WRONG,
                                     last: 1'b1};
                    end else begin
                        addr_next  = (job.op == mslp_pkg::OP_XFER) ? AW'(job.slot) : '0;
                        state_next = S_RD;
                    end
                end
            end
            S_RD: begin
                state_next = S_CHK;
            end
            S_CHK: begin
                unique case (job_reg.op)
                    mslp_pkg::OP_XFER: begin
                        if (out_free) begin
                            wr_en          = match;
                            out_valid_next = 1'b1;
                            out_next = '{slot_out: job_reg.slot,
                                         status: match ? mslp_pkg::STAT_OK
                                                       : mslp_pkg::STAT_WRONG,
                                         last: 1'b1};
                            state_next = S_IDLE;
                        end
                    end
                    mslp_pkg::OP_ALLOC: begin
                        if (match) begin
                            if (out_free) begin
                                wr_en          = 1'b1;
                                out_valid_next = 1'b1;
                                out_next = '{slot_out: 4'(addr_reg),
                                             status: mslp_pkg::STAT_OK, last: 1'b1};
                                state_next = S_IDLE;
                            end
                        end else if (at_last) begin
                            if (out_free) begin
                                out_valid_next = 1'b1;
                                out_next = '{slot_out: 4'd0, status: mslp_pkg::STAT_FULL,
                                             last: 1'b1};
                                state_next = S_IDLE;
                            end
                        end else begin
                            addr_next  = addr_reg + AW'(1);
                            state_next = S_RD;
                        end
                    end
                    default: begin
                        if (match) begin
                            if (cnt_reg == '0 || out_free) begin
                                if (cnt_reg != '0) begin
                                    out_valid_next = 1'b1;
                                    out_next = '{slot_out: 4'(pend_reg),
                                                 status: mslp_pkg::STAT_OK, last: 1'b0};
                                end
                                wr_en     = 1'b1;
                                pend_next = addr_reg;
                                cnt_next  = cnt_inc;
                                if (cnt_inc == CNT_MAX || at_last) begin
                                    state_next = S_FLUSH;
                                end else begin
                                    addr_next  = addr_reg + AW'(1);
                                    state_next = S_RD;
                                end
                            end
                        end else if (at_last) begin
                            state_next = S_FLUSH;
                        end else begin
                            addr_next  = addr_reg + AW'(1);
                            state_next = S_RD;
                        end
                    end
                endcase
            end
            S_FLUSH: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    if (cnt_reg != '0) begin
                        out_next = '{slot_out: 4'(pend_reg), status: mslp_pkg::STAT_OK,
                                     last: 1'b1};
                    end else begin
                        out_next = '{slot_out: 4'd0, status: mslp_pkg::STAT_NONE,
                                     last: 1'b1};
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (wr_en) begin
            valid_next[addr_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg      <= job_next;
        addr_reg     <= addr_next;
        pend_reg     <= pend_next;
        cnt_reg      <= cnt_next;
        out_reg      <= out_next;
        rd_valid_reg <= valid_reg[addr_reg];
    end

endmodule
